>>> rtl/rsi_pkg.sv
`default_nettype none
package rsi_pkg;
  localparam int CoordWidth = 24;
  localparam int DirFracBits = 14;
  localparam int DirWidth = DirFracBits + 2;
  localparam int ThreshWidth = 20;
  localparam logic [ThreshWidth-1:0] ThreshReset = ThreshWidth'(4);
  localparam int ParamWidth = CoordWidth - 1;
  // differences: CoordWidth+1 bits
  localparam int DiffWidth = CoordWidth + 1;
  // det, u numerator: DirWidth + DiffWidth + 1
  localparam int DetWidth = DirWidth + DiffWidth + 1;
  // t numerator: 2*DiffWidth + 1
  localparam int TnWidth = 2 * DiffWidth + 1;
  localparam int DetMagWidth = DetWidth - 1;
  localparam int TnMagWidth = TnWidth - 1;
  // t quotient held below 2^41 (cap 2^40)
  localparam int QWidth = 41;
  localparam int TCapBit = 40;
  // dividend bits after scaling
  localparam int DivSteps = TnMagWidth + DirFracBits;
  localparam int InWidth = 6 * CoordWidth + 2 * DirWidth;
  localparam int InBytes = (InWidth + 7) / 8;
  localparam int OutWidth = 2 * CoordWidth + ParamWidth;
  localparam int OutBytes = (OutWidth + 7) / 8;

  typedef struct packed {
    logic signed [CoordWidth-1:0] origin_x;
    logic signed [CoordWidth-1:0] origin_y;
    logic signed [DirWidth-1:0] dir_x;
    logic signed [DirWidth-1:0] dir_y;
    logic valid;
    logic hit;
  } rsi_side_t;
endpackage
`default_nettype wire

>>> rtl/ray_segment_intersect_unit.sv
`default_nettype none
// Ray against segment intersection, fully pipelined.
// Stages: 3 front + 64 divider + 2 output. Throughput: one word per cycle
// while the output is not stalled; the 64-stage quotient pipeline sets depth.
// A stalled output freezes the whole pipeline (global enable);
// s_tready = !m_tvalid || m_tready.
// Reset (rst, synchronous, high) clears all valid bits and the threshold to 4.
module ray_segment_intersect_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // origin_x, origin_y, dir_x, dir_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
  input  wire logic [rsi_pkg::InBytes*8-1:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // hit_x, hit_y, ray_param
  output logic [rsi_pkg::OutBytes*8-1:0] m_tdata,
  // hit
  output logic m_tuser,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [rsi_pkg::ThreshWidth-1:0] cfg_data
);
  import rsi_pkg::*;

  logic [ThreshWidth-1:0] threshold;
  logic en;
  rsi_side_t f_side, d_side;
  logic [TnMagWidth-1:0] tn_mag;
  logic [DetMagWidth-1:0] det_mag;
  logic [QWidth-1:0] quot;
  logic o_hit;
  logic [CoordWidth-1:0] o_x, o_y;
  logic [ParamWidth-1:0] o_t;

  // pipeline advances unless a finished word waits for the sink
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) threshold <= ThreshReset;
    else if (cfg_valid) threshold <= cfg_data;
  end

  rsi_front u_front (
    .clk, .rst, .en,
    .in_valid (s_tvalid),
    .in_data (s_tdata[InWidth-1:0]),
    .threshold,
    .side (f_side),
    .tn_mag, .det_mag
  );

  rsi_divider u_div (
    .clk, .rst, .en,
    .side_in (f_side),
    .num (tn_mag),
    .den (det_mag),
    .side_out (d_side),
    .quot
  );

  rsi_point u_point (
    .clk, .rst, .en,
    .side (d_side),
    .quot,
    .out_valid (m_tvalid),
    .out_hit (o_hit),
    .out_x (o_x),
    .out_y (o_y),
    .out_t (o_t)
  );

  assign m_tuser = o_hit;
  assign m_tdata = (OutBytes*8)'({o_t, o_y, o_x});
endmodule
`default_nettype wire

>>> rtl/rsi_front.sv
`default_nettype none
// Stage 1: differences; stage 2: cross products; stage 3: hit test and magnitudes.
module rsi_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic [rsi_pkg::InWidth-1:0] in_data,
  input  wire logic [rsi_pkg::ThreshWidth-1:0] threshold,
  output rsi_pkg::rsi_side_t side,
  output logic [rsi_pkg::TnMagWidth-1:0] tn_mag,
  output logic [rsi_pkg::DetMagWidth-1:0] det_mag
);
  import rsi_pkg::*;

  logic signed [CoordWidth-1:0] ox, oy, sx, sy, ex, ey;
  logic signed [DirWidth-1:0] rx, ry;
  assign ox = in_data[CoordWidth-1:0];
  assign oy = in_data[2*CoordWidth-1:CoordWidth];
  assign rx = in_data[2*CoordWidth+DirWidth-1:2*CoordWidth];
  assign ry = in_data[2*CoordWidth+2*DirWidth-1:2*CoordWidth+DirWidth];
  assign sx = in_data[3*CoordWidth+2*DirWidth-1:2*CoordWidth+2*DirWidth];
  assign sy = in_data[4*CoordWidth+2*DirWidth-1:3*CoordWidth+2*DirWidth];
  assign ex = in_data[5*CoordWidth+2*DirWidth-1:4*CoordWidth+2*DirWidth];
  assign ey = in_data[6*CoordWidth+2*DirWidth-1:5*CoordWidth+2*DirWidth];

  rsi_side_t s1, s2;
  logic signed [DiffWidth-1:0] lx, ly, px, py;
  logic signed [DetWidth-1:0] det, un;
  logic signed [TnWidth-1:0] tn;

  logic [DetMagWidth-1:0] dmag;
  logic signed [DetWidth-1:0] uns;
  logic hit3;
  always_comb begin
    dmag = det[DetWidth-1] ? DetMagWidth'(-det) : DetMagWidth'(det);
    uns = det[DetWidth-1] ? -un : un;
    hit3 = 1'b1;
    if (det == '0 || dmag < DetMagWidth'(threshold)) hit3 = 1'b0;
    if (tn != '0 && (tn[TnWidth-1] != det[DetWidth-1])) hit3 = 1'b0;
    if (uns[DetWidth-1] || DetMagWidth'(uns) > dmag) hit3 = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      side.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= in_valid;
      s2.valid <= s1.valid;
      side.valid <= s2.valid;
    end
    if (en) begin
      s1.origin_x <= ox;
      s1.origin_y <= oy;
      s1.dir_x <= rx;
      s1.dir_y <= ry;
      s1.hit <= 1'b0;
      lx <= DiffWidth'(ex) - DiffWidth'(sx);
      ly <= DiffWidth'(ey) - DiffWidth'(sy);
      px <= DiffWidth'(sx) - DiffWidth'(ox);
      py <= DiffWidth'(sy) - DiffWidth'(oy);
      // stage 2
      s2.origin_x <= s1.origin_x;
      s2.origin_y <= s1.origin_y;
      s2.dir_x <= s1.dir_x;
      s2.dir_y <= s1.dir_y;
      s2.hit <= 1'b0;
      det <= DetWidth'(s1.dir_x * ly) - DetWidth'(s1.dir_y * lx);
      un <= DetWidth'(px * s1.dir_y) - DetWidth'(py * s1.dir_x);
      tn <= TnWidth'(px * ly) - TnWidth'(py * lx);
      // stage 3
      side.origin_x <= s2.origin_x;
      side.origin_y <= s2.origin_y;
      side.dir_x <= s2.dir_x;
      side.dir_y <= s2.dir_y;
      side.hit <= hit3;
      tn_mag <= tn[TnWidth-1] ? TnMagWidth'(-tn) : TnMagWidth'(tn);
      det_mag <= dmag;
    end
  end
endmodule
`default_nettype wire

>>> rtl/rsi_divider.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^40.
module rsi_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  rsi_pkg::rsi_side_t side_in,
  input  wire logic [rsi_pkg::TnMagWidth-1:0] num,
  input  wire logic [rsi_pkg::DetMagWidth-1:0] den,
  output rsi_pkg::rsi_side_t side_out,
  output logic [rsi_pkg::QWidth-1:0] quot
);
  import rsi_pkg::*;
  localparam int NumW = DivSteps;

  rsi_side_t sd [DivSteps+1];
  logic [NumW-1:0] n [DivSteps+1];
  logic [DetMagWidth-1:0] d [DivSteps+1];
  logic [DetMagWidth:0] r [DivSteps+1];
  logic [QWidth-1:0] q [DivSteps+1];

  assign sd[0] = side_in;
  assign n[0] = {num, {DirFracBits{1'b0}}};
  assign d[0] = den;
  assign r[0] = '0;
  assign q[0] = '0;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [DetMagWidth:0] r2;
    logic ge;
    logic [QWidth:0] qn;
    always_comb begin
      r2 = {r[i][DetMagWidth-1:0], n[i][NumW-1-i]};
      ge = r2 >= {1'b0, d[i]};
      qn = {q[i], ge};
      if (qn[QWidth:TCapBit] != '0) qn = (QWidth+1)'(1) << TCapBit;
    end
    always_ff @(posedge clk) begin
      if (rst) sd[i+1].valid <= 1'b0;
      else if (en) sd[i+1].valid <= sd[i].valid;
      if (en) begin
        sd[i+1].origin_x <= sd[i].origin_x;
        sd[i+1].origin_y <= sd[i].origin_y;
        sd[i+1].dir_x <= sd[i].dir_x;
        sd[i+1].dir_y <= sd[i].dir_y;
        sd[i+1].hit <= sd[i].hit;
        n[i+1] <= n[i];
        d[i+1] <= d[i];
        r[i+1] <= ge ? r2 - {1'b0, d[i]} : r2;
        q[i+1] <= QWidth'(qn);
      end
    end
  end

  assign side_out = sd[DivSteps];
  assign quot = q[DivSteps];
endmodule
`default_nettype wire

>>> rtl/rsi_point.sv
`default_nettype none
// Stage A: q*dir products; stage B: shift, add, saturate and output register.
module rsi_point (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  rsi_pkg::rsi_side_t side,
  input  wire logic [rsi_pkg::QWidth-1:0] quot,
  output logic out_valid,
  output logic out_hit,
  output logic [rsi_pkg::CoordWidth-1:0] out_x,
  output logic [rsi_pkg::CoordWidth-1:0] out_y,
  output logic [rsi_pkg::ParamWidth-1:0] out_t
);
  import rsi_pkg::*;
  localparam int PW = QWidth + DirWidth + 1;
  localparam int SW = PW + 1;

  rsi_side_t sa;
  logic signed [PW-1:0] mx, my;
  logic [QWidth-1:0] qa;

  function automatic logic [CoordWidth-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    begin
      hi = SW'((64'sd1 <<< (CoordWidth - 1)) - 1);
      lo = -hi - SW'(1);
      if (v > hi) sat = CoordWidth'(hi);
      else if (v < lo) sat = CoordWidth'(lo);
      else sat = CoordWidth'(v);
    end
  endfunction

  // truncate toward zero: bias negatives before the arithmetic shift
  logic signed [PW-1:0] dx, dy;
  logic signed [SW-1:0] hx, hy;
  always_comb begin
    dx = (mx + (mx[PW-1] ? PW'((1 << DirFracBits) - 1) : PW'(0))) >>> DirFracBits;
    dy = (my + (my[PW-1] ? PW'((1 << DirFracBits) - 1) : PW'(0))) >>> DirFracBits;
    hx = SW'(sa.origin_x) + SW'(dx);
    hy = SW'(sa.origin_y) + SW'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sa.valid <= side.valid;
      out_valid <= sa.valid;
    end
    if (en) begin
      sa.origin_x <= side.origin_x;
      sa.origin_y <= side.origin_y;
      sa.dir_x <= side.dir_x;
      sa.dir_y <= side.dir_y;
      sa.hit <= side.hit;
      qa <= quot;
      mx <= $signed({1'b0, quot}) * side.dir_x;
      my <= $signed({1'b0, quot}) * side.dir_y;
      out_hit <= sa.hit;
      out_x <= sa.hit ? sat(hx) : '0;
      out_y <= sa.hit ? sat(hy) : '0;
      out_t <= !sa.hit ? '0 :
               (qa > QWidth'({ParamWidth{1'b1}})) ? {ParamWidth{1'b1}} : ParamWidth'(qa);
    end
  end
endmodule
`default_nettype wire

>>> rtl/rsi_checker.sv
`default_nettype none
module rsi_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [rsi_pkg::OutBytes*8-1:0] m_tdata,
  input wire logic m_tuser
);
  import rsi_pkg::*;
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready) else $error("ready while stalled");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0)) else $error("miss not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("dropped");
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("reset");
endmodule
bind ray_segment_intersect_unit rsi_checker u_chk (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
`default_nettype wire
